// ===== src/gbs_pkg.sv =====
`timescale 1ns / 1ps

package gbs_pkg;

  localparam int unsigned MAX_KEPT_DEF  = 256;
  localparam int unsigned MAX_BOXES_DEF = 8192;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned THR_W   = 16;

  localparam logic [THR_W-1:0] IOU_THR_RESET = 16'd29491;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;    // latch the incoming box
    logic issue;   // read one stored box and advance the scan address
    logic decide;  // settle keep / store full and store the box if it stays and the store has room
    logic emit;    // move the result into the output register
  } gbs_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic count_zero;  // store holds no box
    logic scan_last;   // scan address points at the last stored box
    logic pipe_busy;   // overlap compares still in flight
  } gbs_status_t;

endpackage

// ===== src/gbs_if.sv =====
`timescale 1ns / 1ps

interface gbs_box_if;
  import gbs_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] corner_x;
  logic signed [15:0] corner_y;
  logic        [15:0] box_width;
  logic        [15:0] box_height;
  logic               start_set;

  modport source (
    output valid, corner_x, corner_y, box_width, box_height, start_set,
    input  ready
  );

  modport sink (
    input  valid, corner_x, corner_y, box_width, box_height, start_set,
    output ready
  );
endinterface

interface gbs_result_if;
  import gbs_pkg::*;

  logic             valid;
  logic             ready;
  logic             keep;
  logic [POS_W-1:0] box_position;
  logic             store_full;

  modport source (
    output valid, keep, box_position, store_full,
    input  ready
  );

  modport sink (
    input  valid, keep, box_position, store_full,
    output ready
  );
endinterface

// ===== src/gbs_ram.sv =====
`timescale 1ns / 1ps

module gbs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/gbs_datapath.sv =====
`timescale 1ns / 1ps

module gbs_datapath import gbs_pkg::*; #(
  parameter int unsigned MAX_KEPT  = MAX_KEPT_DEF,
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [THR_W-1:0]   cfg_data_i,
  input  logic signed [15:0] corner_x_i,
  input  logic signed [15:0] corner_y_i,
  input  logic [15:0]        box_width_i,
  input  logic [15:0]        box_height_i,
  input  logic               start_set_i,
  input  gbs_cmd_t           cmd_i,
  output gbs_status_t        status_o,
  output logic               keep_o,
  output logic [POS_W-1:0]   box_position_o,
  output logic               store_full_o
);

  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CW = $clog2(MAX_KEPT + 1);
  localparam int unsigned PosCapInt = ((MAX_BOXES - 1) < 8191) ? (MAX_BOXES - 1) : 8191;
  localparam logic [POS_W-1:0] PosCap  = POS_W'(PosCapInt);
  localparam logic [CW-1:0]    CountMax = CW'(MAX_KEPT);

  logic [THR_W-1:0]   thr_q;
  logic signed [15:0] ax_q, ay_q;
  logic [15:0]        aw_q, ah_q;
  logic [31:0]        area_a_q;
  logic [CW-1:0]      count_q;
  logic [POS_W-1:0]   pos_q;
  logic [AW-1:0]      addr_q;
  logic [5:1]         v_q;
  logic               sup_q;
  logic               res_keep_q, res_full_q;
  logic               out_keep_q, out_full_q;
  logic [POS_W-1:0]   out_pos_q;
  logic               store_en;
  logic [63:0]        rdata;

  // stage 2: overlap extents
  logic signed [15:0] bx, by;
  logic signed [17:0] a_xe, a_ye, b_xe, b_ye, a_xs, a_ys, b_xs, b_ys;
  logic signed [17:0] min_xe, min_ye, max_xs, max_ys;
  logic signed [18:0] iw_d, ih_d;
  logic signed [18:0] iw_q, ih_q;
  logic [15:0]        bw_q, bh_q;
  // stage 3: products
  logic [31:0]        inter_d, inter3_q, area_b_q;
  // stage 4: union
  logic [32:0]        uni_q;
  logic [31:0]        inter4_q;
  // stage 5: scaled union
  logic [48:0]        prod_d, prod_q;
  logic [31:0]        inter5_q;
  logic               hit;

  assign store_en = cmd_i.decide && !sup_q && (count_q != CountMax);

  gbs_ram #(
    .WIDTH (64),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({ah_q, aw_q, ay_q, ax_q}),
    .re_i    (cmd_i.issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= IOU_THR_RESET;
      count_q <= '0;
      pos_q   <= '0;
      addr_q  <= '0;
      v_q     <= '0;
      sup_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      v_q <= {v_q[4:1], cmd_i.issue};
      if (cmd_i.load) begin
        addr_q <= '0;
        sup_q  <= 1'b0;
        if (start_set_i) begin
          count_q <= '0;
          pos_q   <= '0;
        end
      end else begin
        if (cmd_i.issue) begin
          addr_q <= addr_q + AW'(1);
        end
        if (v_q[5] && hit) begin
          sup_q <= 1'b1;
        end
        if (store_en) begin
          count_q <= count_q + CW'(1);
        end
        if (cmd_i.emit && (pos_q < PosCap)) begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
    end
  end

  // box under test, its area and the result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= corner_x_i;
      ay_q <= corner_y_i;
      aw_q <= box_width_i;
      ah_q <= box_height_i;
    end
    area_a_q <= aw_q * ah_q;
    if (cmd_i.decide) begin
      res_keep_q <= !sup_q;
      res_full_q <= !sup_q && (count_q == CountMax);
    end
    if (cmd_i.emit) begin
      out_keep_q <= res_keep_q;
      out_full_q <= res_full_q;
      out_pos_q  <= pos_q;
    end
  end

  always_comb begin
    bx     = rdata[15:0];
    by     = rdata[31:16];
    a_xs   = {{2{ax_q[15]}}, ax_q};
    a_ys   = {{2{ay_q[15]}}, ay_q};
    b_xs   = {{2{bx[15]}}, bx};
    b_ys   = {{2{by[15]}}, by};
    a_xe   = a_xs + {2'b00, aw_q};
    a_ye   = a_ys + {2'b00, ah_q};
    b_xe   = b_xs + {2'b00, rdata[47:32]};
    b_ye   = b_ys + {2'b00, rdata[63:48]};
    min_xe = (a_xe < b_xe) ? a_xe : b_xe;
    min_ye = (a_ye < b_ye) ? a_ye : b_ye;
    max_xs = (a_xs > b_xs) ? a_xs : b_xs;
    max_ys = (a_ys > b_ys) ? a_ys : b_ys;
    iw_d   = {min_xe[17], min_xe} - {max_xs[17], max_xs};
    ih_d   = {min_ye[17], min_ye} - {max_ys[17], max_ys};
  end

  // overlap width and height are at most 16 bits wide when positive
  assign inter_d = ((iw_q > 19'sd0) && (ih_q > 19'sd0)) ? iw_q[15:0] * ih_q[15:0] : 32'd0;
  assign prod_d  = {33'd0, thr_q} * {16'd0, uni_q};
  assign hit     = {1'b0, inter5_q, 16'h0000} > prod_q;

  always_ff @(posedge clk_i) begin
    iw_q     <= iw_d;
    ih_q     <= ih_d;
    bw_q     <= rdata[47:32];
    bh_q     <= rdata[63:48];
    inter3_q <= inter_d;
    area_b_q <= bw_q * bh_q;
    uni_q    <= {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter3_q};
    inter4_q <= inter3_q;
    prod_q   <= prod_d;
    inter5_q <= inter4_q;
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.scan_last  = ({{(CW > AW ? CW - AW : 0){1'b0}}, addr_q} == count_q - CW'(1));
  assign status_o.pipe_busy  = |v_q;

  assign keep_o         = out_keep_q;
  assign store_full_o   = out_full_q;
  assign box_position_o = out_pos_q;

endmodule

// ===== src/gbs_ctrl.sv =====
`timescale 1ns / 1ps

module gbs_ctrl import gbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  gbs_status_t status_i,
  output gbs_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = status_i.count_zero ? ST_DECIDE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/greedy_box_suppression_core.sv =====
`timescale 1ns / 1ps
// channel    dir   handshake       payload
// box_i      in    valid / ready   corner_x, corner_y, box_width, box_height, start_set
// result_o   out   valid / ready   keep, box_position, store_full
// cfg        in    cfg_we_i        cfg_data_i (iou_threshold)
//
// one box at a time: prep, scan, drain, decide and emit, with scan and drain skipped for an empty store
// the scan reads one stored box per cycle from the single read port of the store
// rst_ni clears the sequencer and counters and sets the threshold to IOU_THR_RESET; the store itself is not cleared
// a waiting result does not block the next box, which is taken while it waits
// a stalled result only holds the box after it in its final state

module greedy_box_suppression_core import gbs_pkg::*; #(
  parameter int unsigned MAX_KEPT  = MAX_KEPT_DEF,
  parameter int unsigned MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_data_i,
  gbs_box_if.sink          box_i,
  gbs_result_if.source     result_o
);

  gbs_cmd_t    cmd;
  gbs_status_t status;
  logic        in_ready;
  logic        out_valid;

  // sequencer: walks the stored boxes and paces the output register
  gbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (box_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: box store, overlap pipeline, counters and output register
  gbs_datapath #(
    .MAX_KEPT  (MAX_KEPT),
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .corner_x_i     (box_i.corner_x),
    .corner_y_i     (box_i.corner_y),
    .box_width_i    (box_i.box_width),
    .box_height_i   (box_i.box_height),
    .start_set_i    (box_i.start_set),
    .cmd_i          (cmd),
    .status_o       (status),
    .keep_o         (result_o.keep),
    .box_position_o (result_o.box_position),
    .store_full_o   (result_o.store_full)
  );

  assign box_i.ready    = in_ready;
  assign result_o.valid = out_valid;

endmodule

// ===== src/gbs_checker.sv =====
`timescale 1ns / 1ps

module gbs_checker import gbs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic             res_keep_i,
  input logic             res_full_i,
  input logic [POS_W-1:0] res_pos_i
);

  // one box in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("box taken while another is in work");

  // a suppressed box never reports a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_keep_i) |-> !res_full_i)
    else $error("store full flagged on a suppressed box");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      ($stable(res_keep_i) && $stable(res_full_i) && $stable(res_pos_i)))
    else $error("result changed while stalled");

endmodule

bind greedy_box_suppression_core gbs_checker u_gbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (box_i.valid),
  .in_ready_i  (box_i.ready),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_keep_i  (result_o.keep),
  .res_full_i  (result_o.store_full),
  .res_pos_i   (result_o.box_position)
);

// ===== tb/gbs_nms_checker.sv =====
`timescale 1ns / 1ps

module gbs_nms_checker import gbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_data_i,
  gbs_box_if               box_mon,
  gbs_result_if            result_mon,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned POS_CAP =
    (MAX_BOXES_DEF - 1 < 8191) ? MAX_BOXES_DEF - 1 : 8191;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } box_t;

  typedef struct packed {
    logic             keep;
    logic [POS_W-1:0] pos;
    logic             full;
  } verdict_t;

  box_t             kept_store [MAX_KEPT_DEF];
  int unsigned      kept_total;
  int unsigned      set_index;
  logic [THR_W-1:0] iou_thr;
  verdict_t         verdict_q [$];

  // overlap test without division: inter * 65536 > thr * union
  function automatic bit box_overlap_exceeds(box_t a, box_t b, logic [THR_W-1:0] thr);
    longint      ax, ay, aw, ah, bx, by, bw, bh, iw, ih;
    logic [63:0] inter, area_a, area_b, uni_sum;
    ax = longint'($signed(a.x));
    ay = longint'($signed(a.y));
    aw = longint'(a.w);
    ah = longint'(a.h);
    bx = longint'($signed(b.x));
    by = longint'($signed(b.y));
    bw = longint'(b.w);
    bh = longint'(b.h);
    iw = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ((ax > bx) ? ax : bx);
    ih = ((ay + ah < by + bh) ? ay + ah : by + bh) - ((ay > by) ? ay : by);
    inter = 64'd0;
    if (iw > 0 && ih > 0) inter = 64'(iw) * 64'(ih);
    area_a = 64'(aw) * 64'(ah);
    area_b = 64'(bw) * 64'(bh);
    uni_sum = area_a + area_b - inter;
    return (inter << 16) > (64'(thr) * uni_sum);
  endfunction

  function automatic verdict_t judge_box(box_t b, bit start);
    verdict_t v;
    bit       keep;
    if (start) begin
      kept_total = 0;
      set_index = 0;
    end
    keep = 1'b1;
    for (int i = 0; i < kept_total; i++) begin
      if (box_overlap_exceeds(b, kept_store[i], iou_thr)) keep = 1'b0;
    end
    v.keep = keep;
    v.full = 1'b0;
    v.pos = POS_W'(set_index);
    if (keep) begin
      if (kept_total < MAX_KEPT_DEF) begin
        kept_store[kept_total] = b;
        kept_total++;
      end else begin
        v.full = 1'b1;
      end
    end
    if (set_index < POS_CAP) set_index++;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    verdict_t new_v;
    box_t     b;
    if (!rst_ni) begin
      kept_total = 0;
      set_index = 0;
      iou_thr = IOU_THR_RESET;
      verdict_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) iou_thr = cfg_data_i;
      // result side first, so a result can only match an older box
      if (result_mon.valid && result_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with no box outstanding");
          fail_count_o++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (result_mon.keep !== exp_v.keep) begin
            $error("keep mismatch: expected %0d, actual %0d", exp_v.keep, result_mon.keep);
            fail_count_o++;
          end
          if (result_mon.box_position !== exp_v.pos) begin
            $error("box_position mismatch: expected %0d, actual %0d",
                   exp_v.pos, result_mon.box_position);
            fail_count_o++;
          end
          if (result_mon.store_full !== exp_v.full) begin
            $error("store_full mismatch: expected %0d, actual %0d",
                   exp_v.full, result_mon.store_full);
            fail_count_o++;
          end
        end
      end
      if (box_mon.valid && box_mon.ready) begin
        b.x = box_mon.corner_x;
        b.y = box_mon.corner_y;
        b.w = box_mon.box_width;
        b.h = box_mon.box_height;
        new_v = judge_box(b, box_mon.start_set);
        verdict_q.insert(verdict_q.size(), new_v);
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gbs_pkg::*;

  // enough disjoint boxes to overflow the kept store
  localparam int unsigned FULL_SET   = MAX_KEPT_DEF + 4;
  localparam int unsigned PHASE_LEN  = 75;
  localparam int unsigned HOLD_LEN   = 400;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_data;

  // calm: no idling on either side; hold_req: one long receiver stall
  bit          calm;
  bit          hold_req;
  int unsigned fail_count;
  int unsigned pending;

  gbs_box_if    box_if ();
  gbs_result_if result_if ();

  greedy_box_suppression_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .box_i      (box_if),
    .result_o   (result_if)
  );

  gbs_nms_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .box_mon      (box_if),
    .result_mon   (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #15ms;
    $display("Simulation FAILED");
    $finish;
  end

  // result receiver: random backpressure, one long hold-off, calm stretch
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (calm) begin
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= ($urandom_range(99) >= 10);
      end
    end
  end

  // offer one box and wait for its transfer; valid stays high afterwards
  task automatic send_box(input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] w, input logic [15:0] h, input bit st);
    while (!calm && $urandom_range(99) < 10) begin
      box_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    box_if.valid      <= 1'b1;
    box_if.corner_x   <= x;
    box_if.corner_y   <= y;
    box_if.box_width  <= w;
    box_if.box_height <= h;
    box_if.start_set  <= st;
    @(posedge clk_i);
    while (!box_if.ready) @(posedge clk_i);
  endtask

  // stop offering and wait until every outstanding result is back
  task automatic drain;
    box_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // threshold writes only happen with the block idle
  task automatic write_threshold(input logic [THR_W-1:0] v);
    drain;
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // one set of boxes clustered around a random center, with some outliers
  task automatic random_set(input int unsigned len);
    int cx, cy, bw, bh, spread, x, y, w, h;
    int unsigned kind;
    bit st;
    cx = int'($urandom_range(4000)) - 2000;
    cy = int'($urandom_range(4000)) - 2000;
    bw = int'($urandom_range(1, 800));
    bh = int'($urandom_range(1, 800));
    spread = int'($urandom_range(1, 200));
    for (int k = 0; k < len; k++) begin
      // most sets open with a start flag; a few are broken or restart midway
      if (k == 0) st = ($urandom_range(99) < 85);
      else st = ($urandom_range(99) < 3);
      kind = $urandom_range(19);
      x = cx + int'($urandom_range(2 * spread)) - spread;
      y = cy + int'($urandom_range(2 * spread)) - spread;
      w = bw + int'($urandom_range(spread));
      h = bh + int'($urandom_range(spread));
      if (kind < 2) begin
        // fully random fields cover every bit and the extremes
        x = int'($urandom);
        y = int'($urandom);
        w = int'($urandom);
        h = int'($urandom);
      end else if (kind == 2) begin
        w = 0;
      end else if (kind == 3) begin
        h = 0;
      end
      send_box(16'(x), 16'(y), 16'(w), 16'(h), st);
    end
  endtask

  initial begin : stimulus
    logic [THR_W-1:0] thr_list [6];
    int unsigned      sent;
    int unsigned      len;

    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    calm                 = 1'b0;
    hold_req             = 1'b0;
    box_if.valid         = 1'b0;
    box_if.corner_x      = '0;
    box_if.corner_y      = '0;
    box_if.box_width     = '0;
    box_if.box_height    = '0;
    box_if.start_set     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset threshold
    // largest box, then a copy of it which is suppressed
    send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1);
    send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0);
    // starts exactly at the right edge of the first: empty intersection
    send_box(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
    // zero-area boxes: zero union, always kept
    send_box(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_box(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_box(16'd100, 16'd100, 16'd0, 16'd500, 1'b0);
    // touching boxes, then one third overlap, then heavy overlap
    send_box(16'd0, 16'd0, 16'd160, 16'd160, 1'b0);
    send_box(16'd160, 16'd0, 16'd160, 16'd160, 1'b0);
    send_box(16'd80, 16'd0, 16'd160, 16'd160, 1'b0);
    send_box(16'd8, 16'd8, 16'd160, 16'd160, 1'b0);
    send_box(16'h8000, 16'h7FFF, 16'd1, 16'd1, 1'b0);
    send_box(16'h7FFF, 16'h8000, 16'hFFFF, 16'd1, 1'b0);
    // new set in the middle: store clears, index back to zero
    send_box(16'd0, 16'd0, 16'd160, 16'd160, 1'b1);
    send_box(16'd40, 16'd0, 16'd160, 16'd160, 1'b0);
    send_box(16'd70, 16'd0, 16'd160, 16'd160, 1'b0);
    send_box(16'hFFFF, 16'hFFFF, 16'd2, 16'd2, 1'b0);

    // zero threshold: any overlap at all suppresses
    write_threshold('0);
    send_box(16'd0, 16'd0, 16'd16, 16'd16, 1'b1);
    send_box(16'd15, 16'd15, 16'd16, 16'd16, 1'b0);
    send_box(16'd16, 16'd16, 16'd16, 16'd16, 1'b0);

    // top threshold: only a near copy suppresses
    write_threshold('1);
    send_box(16'd0, 16'd0, 16'd16, 16'd16, 1'b1);
    send_box(16'd0, 16'd0, 16'd16, 16'd16, 1'b0);
    send_box(16'd1, 16'd0, 16'd16, 16'd16, 1'b0);

    // random part in phases, one threshold setting per phase
    thr_list[0] = '0;
    thr_list[1] = '1;
    thr_list[2] = IOU_THR_RESET;
    thr_list[3] = 16'd16384;
    thr_list[4] = 16'd52000;
    thr_list[5] = THR_W'($urandom_range(65535));
    for (int p = 0; p < 6; p++) begin
      write_threshold(thr_list[p]);
      calm = (p == 2);
      hold_req = (p == 1);
      sent = 0;
      while (sent < PHASE_LEN) begin
        if ($urandom_range(9) == 0) len = $urandom_range(25, 60);
        else len = $urandom_range(1, 24);
        random_set(len);
        sent += len;
      end
      calm = 1'b0;
    end

    // disjoint boxes overflow the store; later kept boxes get the full flag
    write_threshold(IOU_THR_RESET);
    for (int k = 0; k < FULL_SET; k++) begin
      send_box(16'(k * 16), 16'hFF9C, 16'd8, 16'd8, (k == 0));
    end
    // copy of a stored box: suppressed, no full flag
    send_box(16'd0, 16'hFF9C, 16'd8, 16'd8, 1'b0);
    // copy of a box that never made it into the store: kept, full
    send_box(16'((FULL_SET - 1) * 16), 16'hFF9C, 16'd8, 16'd8, 1'b0);

    // wait out the tail and any late, unexpected result
    drain;
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
